### src/fibonacci_matrix_power_assert.svh
// ----------------------------------------------------------------------------
// Fibonacci matrix power assertion macros
// Shared property templates for the port checker. Each macro expects clk and
// rst_n to be visible in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef FIBONACCI_MATRIX_POWER_ASSERT_SVH
`define FIBONACCI_MATRIX_POWER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FMP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FMP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold at a later cycle than the antecedent.
`define FMP_ASSERT_LATER(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error(msg);

`endif

### src/fmp_pkg.sv
// ----------------------------------------------------------------------------
// Fibonacci matrix power package
// Widths, limits and sequencer types shared by the block and its checker.
// ----------------------------------------------------------------------------
package fmp_pkg;

    localparam int EXP_W  = 7;
    localparam int FIB_W  = 63;
    localparam int HALF_W = 32;

    // Largest exponent whose F(p+1) still fits in FIB_W bits.
    localparam int FMP_MAX_EXPONENT = 91;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_MUL,
        ST_DRAIN
    } fmp_state_t;

    // Which of the four products of a pair multiply is being formed.
    typedef enum logic [1:0] {
        T_AD,
        T_DC,
        T_BD,
        T_AC
    } term_t;

    // Which 32 by 32 slice of a product is being formed.
    typedef enum logic [1:0] {
        CH_LL,
        CH_LH,
        CH_HL
    } chunk_t;

endpackage

### src/fibonacci_matrix_power.sv
// ----------------------------------------------------------------------------
// Fibonacci matrix power
// Done follows start in the next cycle for an out-of-range exponent, and for
// p = 0 after one pass through ST_DECIDE; any other p runs one pair multiply
// per set bit and one squaring per bit below its top one. One word at a time:
// start is taken only in idle, and the single 32x32 multiplier sets the pace.
// Reset (rst_n low, asynchronous) returns the sequencer to idle, no done pulse.
// ----------------------------------------------------------------------------
//
// Every power of Q = [[0,1],[1,1]] has the form [[F(n-1),F(n)],[F(n),F(n+1)]],
// so a matrix is held as the pair (a, b) = (F(n), F(n+1)), with F(n-1) = b - a.
// The product of two such pairs (a, b) and (c, d) is
//     a' = a*d + (b - a)*c
//     b' = b*d + a*c
// Square-and-multiply walks the exponent from its low bit: the accumulator
// pair starts as the identity (0, 1), the base pair as Q itself (1, 1).
//
// Each 63 by 63 product is needed only modulo 2^63, and for every legal
// exponent no value ever exceeds 63 bits. A product therefore takes three
// passes through one 32x32 multiplier: low*low, low*high and high*low, the
// last two shifted up by 32. The high*high slice falls entirely above bit 63.
// A pair multiply issues four products of three slices each, and the
// registered partial product is folded into one of two running sums in the
// next cycle by the single shared adder, so the ST_DRAIN state closes it.
//
// The receiver cannot stall: done is a one-cycle strobe and the result ports
// hold their value until the next word is finished.

module fibonacci_matrix_power #(
    parameter int MAX_EXPONENT = fmp_pkg::FMP_MAX_EXPONENT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [fmp_pkg::EXP_W-1:0]  exponent,
    output logic                       busy,
    output logic                       done,
    output logic [fmp_pkg::FIB_W-1:0]  fib_next,
    output logic [fmp_pkg::FIB_W-1:0]  fib_this,
    output logic                       out_of_range
);

    import fmp_pkg::*;

    localparam int TOP_W = FIB_W - HALF_W;

    // Control state.
    fmp_state_t state_reg, state_next;
    logic       phase_reg, phase_next;      // 0: accumulator step, 1: base step
    logic       tgt_base_reg, tgt_base_next;
    term_t      term_reg, term_next;
    chunk_t     chunk_reg, chunk_next;
    logic       pp_valid_reg, pp_valid_next;
    logic       done_reg, done_next;

    // Datapath registers.
    logic [EXP_W-1:0]    p_reg, p_next;
    logic [FIB_W-1:0]    acc_a_reg, acc_a_next, acc_b_reg, acc_b_next;
    logic [FIB_W-1:0]    base_a_reg, base_a_next, base_b_reg, base_b_next;
    logic [FIB_W-1:0]    diff_reg, diff_next;
    logic [FIB_W-1:0]    sum_a_reg, sum_a_next, sum_b_reg, sum_b_next;
    logic [2*HALF_W-1:0] prod_reg, prod_next;
    logic                pp_hi_reg, pp_hi_next;
    logic                pp_to_b_reg, pp_to_b_next;
    logic [FIB_W-1:0]    res_hi_reg, res_hi_next, res_lo_reg, res_lo_next;
    logic                oor_reg, oor_next;

    // Shared arithmetic.
    logic [FIB_W-1:0]    y_a, y_b, op_x, op_y;
    logic [HALF_W-1:0]   mul_a, mul_b;
    logic [2*HALF_W-1:0] mul_p;
    logic [FIB_W-1:0]    addend, add_in, add_out;

    // The second operand is the accumulator when folding in a set bit and the
    // base itself when squaring; the first operand is always the base.
    assign y_a = tgt_base_reg ? base_a_reg : acc_a_reg;
    assign y_b = tgt_base_reg ? base_b_reg : acc_b_reg;

    always_comb
    begin
        case (term_reg)
            T_AD:
            begin
                op_x = base_a_reg;
                op_y = y_b;
            end
            T_DC:
            begin
                op_x = diff_reg;
                op_y = y_a;
            end
            T_BD:
            begin
                op_x = base_b_reg;
                op_y = y_b;
            end
            default:
            begin
                op_x = base_a_reg;
                op_y = y_a;
            end
        endcase

        case (chunk_reg)
            CH_LL:
            begin
                mul_a = op_x[HALF_W-1:0];
                mul_b = op_y[HALF_W-1:0];
            end
            CH_LH:
            begin
                mul_a = op_x[HALF_W-1:0];
                mul_b = HALF_W'(op_y[FIB_W-1:HALF_W]);
            end
            default:
            begin
                mul_a = HALF_W'(op_x[FIB_W-1:HALF_W]);
                mul_b = op_y[HALF_W-1:0];
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Cross slices land 32 bits up; only their low 31 bits survive mod 2^63.
    assign addend  = pp_hi_reg ? {prod_reg[TOP_W-1:0], HALF_W'(0)} : prod_reg[FIB_W-1:0];
    assign add_in  = pp_to_b_reg ? sum_b_reg : sum_a_reg;
    assign add_out = add_in + addend;

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        tgt_base_next = tgt_base_reg;
        term_next     = term_reg;
        chunk_next    = chunk_reg;
        pp_valid_next = 1'b0;
        done_next     = 1'b0;
        p_next        = p_reg;
        acc_a_next    = acc_a_reg;
        acc_b_next    = acc_b_reg;
        base_a_next   = base_a_reg;
        base_b_next   = base_b_reg;
        diff_next     = diff_reg;
        sum_a_next    = sum_a_reg;
        sum_b_next    = sum_b_reg;
        prod_next     = mul_p;
        pp_hi_next    = (chunk_reg != CH_LL);
        pp_to_b_next  = (term_reg == T_BD) || (term_reg == T_AC);
        res_hi_next   = res_hi_reg;
        res_lo_next   = res_lo_reg;
        oor_next      = oor_reg;

        // Fold the previous cycle's slice into its running sum.
        if (pp_valid_reg)
        begin
            if (pp_to_b_reg)
            begin
                sum_b_next = add_out;
            end
            else
            begin
                sum_a_next = add_out;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (exponent > EXP_W'(MAX_EXPONENT))
                    begin
                        done_next   = 1'b1;
                        oor_next    = 1'b1;
                        res_hi_next = '0;
                        res_lo_next = '0;
                    end
                    else
                    begin
                        p_next      = exponent;
                        acc_a_next  = '0;
                        acc_b_next  = FIB_W'(1);
                        base_a_next = FIB_W'(1);
                        base_b_next = FIB_W'(1);
                        phase_next  = 1'b0;
                        state_next  = ST_DECIDE;
                    end
                end
            end

            ST_DECIDE:
            begin
                if (!phase_reg)
                begin
                    if (p_reg == '0)
                    begin
                        // Only reachable for a zero exponent: the identity.
                        state_next  = ST_IDLE;
                        done_next   = 1'b1;
                        oor_next    = 1'b0;
                        res_hi_next = acc_b_reg;
                        res_lo_next = acc_a_reg;
                    end
                    else
                    begin
                        phase_next = 1'b1;
                        if (p_reg[0])
                        begin
                            tgt_base_next = 1'b0;
                            term_next     = T_AD;
                            chunk_next    = CH_LL;
                            sum_a_next    = '0;
                            sum_b_next    = '0;
                            diff_next     = base_b_reg - base_a_reg;
                            state_next    = ST_MUL;
                        end
                    end
                end
                else
                begin
                    p_next = p_reg >> 1;
                    if (p_reg[EXP_W-1:1] != '0)
                    begin
                        phase_next    = 1'b0;
                        tgt_base_next = 1'b1;
                        term_next     = T_AD;
                        chunk_next    = CH_LL;
                        sum_a_next    = '0;
                        sum_b_next    = '0;
                        diff_next     = base_b_reg - base_a_reg;
                        state_next    = ST_MUL;
                    end
                    else
                    begin
                        state_next  = ST_IDLE;
                        done_next   = 1'b1;
                        oor_next    = 1'b0;
                        res_hi_next = acc_b_reg;
                        res_lo_next = acc_a_reg;
                    end
                end
            end

            ST_MUL:
            begin
                pp_valid_next = 1'b1;
                case (chunk_reg)
                    CH_LL:   chunk_next = CH_LH;
                    CH_LH:   chunk_next = CH_HL;
                    default:
                    begin
                        chunk_next = CH_LL;
                        case (term_reg)
                            T_AD:    term_next = T_DC;
                            T_DC:    term_next = T_BD;
                            T_BD:    term_next = T_AC;
                            default: state_next = ST_DRAIN;
                        endcase
                    end
                endcase
            end

            ST_DRAIN:
            begin
                // The last slice always belongs to the b sum.
                if (tgt_base_reg)
                begin
                    base_a_next = sum_a_reg;
                    base_b_next = add_out;
                end
                else
                begin
                    acc_a_next = sum_a_reg;
                    acc_b_next = add_out;
                end
                state_next = ST_DECIDE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            phase_reg    <= 1'b0;
            tgt_base_reg <= 1'b0;
            term_reg     <= T_AD;
            chunk_reg    <= CH_LL;
            pp_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            tgt_base_reg <= tgt_base_next;
            term_reg     <= term_next;
            chunk_reg    <= chunk_next;
            pp_valid_reg <= pp_valid_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg       <= p_next;
        acc_a_reg   <= acc_a_next;
        acc_b_reg   <= acc_b_next;
        base_a_reg  <= base_a_next;
        base_b_reg  <= base_b_next;
        diff_reg    <= diff_next;
        sum_a_reg   <= sum_a_next;
        sum_b_reg   <= sum_b_next;
        prod_reg    <= prod_next;
        pp_hi_reg   <= pp_hi_next;
        pp_to_b_reg <= pp_to_b_next;
        res_hi_reg  <= res_hi_next;
        res_lo_reg  <= res_lo_next;
        oor_reg     <= oor_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign fib_next     = res_hi_reg;
    assign fib_this     = res_lo_reg;
    assign out_of_range = oor_reg;

endmodule

### src/fmp_port_checker.sv
// ----------------------------------------------------------------------------
// Fibonacci matrix power port checker
// Watches the ports of the block over time and is bound into the block itself.
// ----------------------------------------------------------------------------
`include "fibonacci_matrix_power_assert.svh"

module fmp_port_checker #(
    parameter int MAX_EXPONENT = fmp_pkg::FMP_MAX_EXPONENT
) (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input logic [fmp_pkg::EXP_W-1:0] exponent,
    input logic                      busy,
    input logic                      done,
    input logic [fmp_pkg::FIB_W-1:0] fib_next,
    input logic [fmp_pkg::FIB_W-1:0] fib_this,
    input logic                      out_of_range
);

    import fmp_pkg::*;

    logic accept;
    logic too_big;
    logic is_zero;
    logic identity_word;

    assign accept        = start && !busy;
    assign too_big       = exponent > EXP_W'(MAX_EXPONENT);
    assign is_zero       = (exponent == '0);
    assign identity_word = done && fib_next == FIB_W'(1) && fib_this == '0 && !out_of_range;

    // An exponent beyond the limit is answered at once with the flag set.
    `FMP_ASSERT_NEXT(a_oor_fast, accept && too_big, done && out_of_range, "late oor word")

    // A zero exponent gives the identity once the sequencer has passed through its decide state.
    `FMP_ASSERT_LATER(a_zero_identity, accept && is_zero, identity_word, "bad identity word")

    // A flagged word carries zero results.
    `FMP_ASSERT_SAME(a_oor_zero, done && out_of_range, fib_next == '0 && fib_this == '0, "oor word not zero")

    // A legal exponent keeps the block busy in the following cycle.
    `FMP_ASSERT_NEXT(a_busy_after, accept && !too_big, busy, "not busy after start")

    // A finished word is only shown while the block is free again.
    `FMP_ASSERT_SAME(a_done_idle, done, !busy, "done while busy")

endmodule

bind fibonacci_matrix_power fmp_port_checker #(
    .MAX_EXPONENT(MAX_EXPONENT)
) u_fmp_port_checker (.*);

### bench/fibonacci_matrix_power_test.sv
// ----------------------------------------------------------------------------
// Fibonacci matrix power testbench
// Sends exponents through the start/busy command port, predicts each word
// (F(p+1), F(p) and the range flag) by square-and-multiply of the Fibonacci
// matrix, and compares every done strobe with the oldest pending prediction.
// ----------------------------------------------------------------------------
module fibonacci_matrix_power_test;

    timeunit 1ns;
    timeprecision 1ps;

    import fmp_pkg::*;

    // One word as the block reports it.
    typedef struct packed {
        logic [FIB_W-1:0] fib_next;
        logic [FIB_W-1:0] fib_this;
        logic             out_of_range;
    } fib_word_t;

    // A 2x2 matrix held modulo 2^64, row by row.
    typedef struct packed {
        bit [63:0] m00;
        bit [63:0] m01;
        bit [63:0] m10;
        bit [63:0] m11;
    } fib_mat_t;

    // The scoreboard keeps the predicted words in issue order. The block has
    // no state between words, so the prediction depends on the exponent only.
    class fib_scoreboard;
        fib_word_t pending_words[$];
        int        mismatches    = 0;
        int        words_checked = 0;
        int        in_range_sent = 0;
        int        over_sent     = 0;

        function fib_mat_t mat_mul(fib_mat_t x, fib_mat_t y);
            fib_mat_t r;
            r.m00 = x.m00 * y.m00 + x.m01 * y.m10;
            r.m01 = x.m00 * y.m01 + x.m01 * y.m11;
            r.m10 = x.m10 * y.m00 + x.m11 * y.m10;
            r.m11 = x.m10 * y.m01 + x.m11 * y.m11;
            return r;
        endfunction

        // Walks the exponent from its lowest bit, squaring the base while higher bits remain.
        function fib_word_t predict_fib(logic [EXP_W-1:0] p);
            fib_word_t        w;
            fib_mat_t         acc;
            fib_mat_t         base;
            logic [EXP_W-1:0] rest;
            w    = '0;
            rest = p;
            if (p > FMP_MAX_EXPONENT) begin
                w.out_of_range = 1'b1;
                return w;
            end
            acc  = '{m00: 64'd1, m01: 64'd0, m10: 64'd0, m11: 64'd1};
            base = '{m00: 64'd0, m01: 64'd1, m10: 64'd1, m11: 64'd1};
            while (rest != 0) begin
                if (rest[0])
                    acc = mat_mul(base, acc);
                rest = rest >> 1;
                if (rest != 0)
                    base = mat_mul(base, base);
            end
            w.fib_next = acc.m11[FIB_W-1:0];
            w.fib_this = acc.m10[FIB_W-1:0];
            return w;
        endfunction

        function void note_exponent(logic [EXP_W-1:0] p);
            if (p > FMP_MAX_EXPONENT)
                over_sent++;
            else
                in_range_sent++;
            pending_words.push_back(predict_fib(p));
        endfunction

        function void report(string what);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] mismatch: %s", $realtime, what);
        endfunction

        function void check_word(fib_word_t got);
            fib_word_t want;
            if (pending_words.size() == 0) begin
                report($sformatf("word with nothing pending: next=%0d this=%0d oor=%0b",
                                 got.fib_next, got.fib_this, got.out_of_range));
                return;
            end
            want = pending_words.pop_front();
            words_checked++;
            if (got.fib_next !== want.fib_next)
                report($sformatf("fib_next expected %0d, got %0d",
                                 want.fib_next, got.fib_next));
            if (got.fib_this !== want.fib_this)
                report($sformatf("fib_this expected %0d, got %0d",
                                 want.fib_this, got.fib_this));
            if (got.out_of_range !== want.out_of_range)
                report($sformatf("out_of_range expected %0b, got %0b",
                                 want.out_of_range, got.out_of_range));
        endfunction
    endclass

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 5;
    // More than ten times the slowest word plus the longest gap is a generous
    // bound for a stretch with nothing moving.
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 250;
    localparam int RANDOM_WORDS  = 1400;
    // The last stretch of random words runs back to back.
    localparam int CALM_WORDS    = 200;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic [EXP_W-1:0] exponent;
    logic             busy;
    logic             done;
    logic [FIB_W-1:0] fib_next;
    logic [FIB_W-1:0] fib_this;
    logic             out_of_range;

    fib_scoreboard sb;
    int            quiet_cycles;

    fibonacci_matrix_power i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .exponent     (exponent),
        .busy         (busy),
        .done         (done),
        .fib_next     (fib_next),
        .fib_this     (fib_this),
        .out_of_range (out_of_range)
    );

    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    // Every done strobe is a word that must be taken in that very cycle, so
    // the monitor looks at the outputs on each rising edge.
    always @(posedge clk) begin
        if (rst_n && done === 1'b1)
            sb.check_word('{fib_next: fib_next, fib_this: fib_this,
                            out_of_range: out_of_range});
    end

    // Watchdog: counts cycles in which neither an exponent is taken nor a
    // word comes out. A hung block or a lost handshake ends the run here.
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || done === 1'b1) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: nothing moved for %0d cycles", STALL_LIMIT);
            $display("** fibonacci_matrix_power: FAILED **");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Sends one exponent. Inputs change on the falling edge only. While start
    // is low the exponent carries noise, which the block must ignore. Start
    // stays high after acceptance until the next call either drives a fresh
    // exponent or drops it for a gap, so it is never pulsed within one step.
    task automatic send_exponent(input logic [EXP_W-1:0] p, input int gap);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) begin
                exponent = EXP_W'($urandom);
                @(negedge clk);
            end
        end
        start    = 1'b1;
        exponent = p;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_exponent(p);
        @(negedge clk);
    endtask

    // Holds the sender back until every predicted word has come out.
    task automatic drain_words();
        start    = 1'b0;
        exponent = EXP_W'($urandom);
        while (sb.pending_words.size() != 0)
            @(negedge clk);
    endtask

    // Most random exponents are legal, a share sits on the edge of the range,
    // and the rest span the full 7-bit field.
    function automatic logic [EXP_W-1:0] pick_exponent();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 7)
            return EXP_W'($urandom_range(0, FMP_MAX_EXPONENT));
        else if (kind == 7)
            return EXP_W'($urandom_range(FMP_MAX_EXPONENT - 3, FMP_MAX_EXPONENT + 4));
        else
            return EXP_W'($urandom_range(0, (1 << EXP_W) - 1));
    endfunction

    initial begin
        logic [EXP_W-1:0] directed[];
        bit idling;
        int gap;

        // Zero, one, the range edge, the top of the field, all-ones below the
        // edge, alternating bit patterns and single high bits.
        directed = '{
            7'd0, 7'd1, 7'd2, 7'd3, 7'd5, 7'd8,
            7'd91, 7'd92, 7'd127, 7'd90, 7'd89, 7'd64,
            7'd63, 7'd85, 7'd42, 7'd32, 7'd16, 7'd100,
            7'd0, 7'd91, 7'd126, 7'd93, 7'd31, 7'd77
        };

        sb           = new();
        rst_n        = 1'b0;
        start        = 1'b0;
        exponent     = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed words go back to back, except for a gap now and then so
        // that a new start also lands right after done.
        foreach (directed[i])
            send_exponent(directed[i], (i % 5 == 4) ? 1 : 0);
        drain_words();

        idling = 1'b1;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            // Idling is switched on and off in stretches of 64 words.
            if (n % 64 == 0)
                idling = ($urandom_range(0, 3) != 0);
            gap = 0;
            if (idling && n < RANDOM_WORDS - CALM_WORDS && $urandom_range(0, 2) == 0)
                gap = $urandom_range(1, 3);
            send_exponent(pick_exponent(), gap);
            // Midway the sender waits for the pipeline to empty completely.
            if (n == RANDOM_WORDS / 2)
                drain_words();
        end
        drain_words();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d exponents (%0d in range, %0d beyond it), checked %0d words.",
                 sb.in_range_sent + sb.over_sent, sb.in_range_sent, sb.over_sent,
                 sb.words_checked);
        $display("Gaps of 1 to 3 cycles, back-to-back stretches and a full drain midway.");
        if (sb.mismatches == 0 && sb.pending_words.size() == 0) begin
            $display("** fibonacci_matrix_power: PASSED **");
        end
        else begin
            $display("%0d mismatches, %0d words never came out",
                     sb.mismatches, sb.pending_words.size());
            $display("** fibonacci_matrix_power: FAILED **");
        end
        $finish;
    end

endmodule
